// File: hw/rtl/rrs_pkg.sv
// Shared types, constants and the microcode program of the rotating record store.
// Used by the sequencer, the datapath and the top level; depends on nothing else.
package rrs_pkg;

  localparam int unsigned DEF_RECORD_BYTES = 8;
  localparam int unsigned DEF_SLOT_COUNT   = 16;

  localparam int unsigned SLOT_OUT_W = 4;
  localparam int unsigned BYTE_W     = 8;

  localparam logic [BYTE_W-1:0] BYTE_ERASED = 8'hFF;
  localparam logic [BYTE_W-1:0] MARK_MASK   = 8'h7F;

  // Step counter of the microcode sequencer.
  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE     = 4'd0;
  localparam step_t ST_SCAN_RD  = 4'd1;
  localparam step_t ST_SCAN_CK  = 4'd2;
  localparam step_t ST_SCAN_NX  = 4'd3;
  localparam step_t ST_MISS     = 4'd4;
  localparam step_t ST_NOTFOUND = 4'd5;
  localparam step_t ST_HIT      = 4'd6;
  localparam step_t ST_LOAD     = 4'd7;
  localparam step_t ST_CMP      = 4'd8;
  localparam step_t ST_CMP_END  = 4'd9;
  localparam step_t ST_ERASE    = 4'd10;
  localparam step_t ST_COPY     = 4'd11;
  localparam step_t ST_EMIT     = 4'd12;

  typedef enum logic [1:0] {
    MEM_NONE = 2'd0,
    MEM_RD   = 2'd1,
    MEM_WR   = 2'd2
  } mem_op_e;

  typedef enum logic [1:0] {
    ADDR_CUR       = 2'd0,
    ADDR_SLOT_NEXT = 2'd1,
    ADDR_IDX_NEXT  = 2'd2
  } addr_sel_e;

  typedef enum logic {
    WD_ERASED = 1'b0,
    WD_STAGE  = 1'b1
  } wdata_sel_e;

  typedef enum logic [1:0] {
    EMIT_NONE     = 2'd0,
    EMIT_NOTFOUND = 2'd1,
    EMIT_LOAD     = 2'd2,
    EMIT_SAVE     = 2'd3
  } emit_e;

  typedef enum logic [2:0] {
    C_NEVER     = 3'd0,
    C_ALWAYS    = 3'd1,
    C_MARK_CLR  = 3'd2,
    C_LAST_SLOT = 3'd3,
    C_IS_SAVE   = 3'd4,
    C_LAST_BYTE = 3'd5,
    C_DIFF      = 3'd6
  } cond_e;

  // One control word per step. When the condition (xor cond_inv) holds the
  // sequencer jumps to target, otherwise it holds or steps to the next word.
  typedef struct packed {
    mem_op_e    mem_op;
    addr_sel_e  addr_sel;
    wdata_sel_e wdata_sel;
    logic       slot_inc;
    logic       idx_inc;
    logic       diff_acc;
    emit_e      emit;
    cond_e      cond;
    logic       cond_inv;
    logic       hold;
    step_t      target;
  } ctrl_t;

  typedef struct packed {
    logic go;
    logic mark_clr;
    logic last_slot;
    logic is_save;
    logic last_byte;
    logic diff;
  } stat_t;

  function automatic ctrl_t ucode(step_t pc);
    ctrl_t w;
    w = '0;
    case (pc)
      ST_IDLE: begin
        w.cond   = C_ALWAYS;
        w.target = ST_IDLE;
      end
      ST_SCAN_RD: begin
        w.mem_op = MEM_RD;
      end
      ST_SCAN_CK: begin
        w.cond   = C_MARK_CLR;
        w.target = ST_HIT;
      end
      ST_SCAN_NX: begin
        // Read the next marker while moving on; after the last slot the
        // slot index has wrapped to zero, which is what a miss needs.
        w.mem_op   = MEM_RD;
        w.addr_sel = ADDR_SLOT_NEXT;
        w.slot_inc = 1'b1;
        w.cond     = C_LAST_SLOT;
        w.cond_inv = 1'b1;
        w.target   = ST_SCAN_CK;
      end
      ST_MISS: begin
        w.mem_op = MEM_RD;
        w.cond   = C_IS_SAVE;
        w.target = ST_CMP;
      end
      ST_NOTFOUND: begin
        w.emit   = EMIT_NOTFOUND;
        w.cond   = C_ALWAYS;
        w.target = ST_IDLE;
      end
      ST_HIT: begin
        w.mem_op = MEM_RD;
        w.cond   = C_IS_SAVE;
        w.target = ST_CMP;
      end
      ST_LOAD: begin
        w.mem_op   = MEM_RD;
        w.addr_sel = ADDR_IDX_NEXT;
        w.idx_inc  = 1'b1;
        w.emit     = EMIT_LOAD;
        w.cond     = C_LAST_BYTE;
        w.hold     = 1'b1;
        w.target   = ST_IDLE;
      end
      ST_CMP: begin
        w.mem_op   = MEM_RD;
        w.addr_sel = ADDR_IDX_NEXT;
        w.idx_inc  = 1'b1;
        w.diff_acc = 1'b1;
        w.cond     = C_LAST_BYTE;
        w.hold     = 1'b1;
        w.target   = ST_CMP_END;
      end
      ST_CMP_END: begin
        w.cond     = C_DIFF;
        w.cond_inv = 1'b1;
        w.target   = ST_EMIT;
      end
      ST_ERASE: begin
        w.mem_op    = MEM_WR;
        w.wdata_sel = WD_ERASED;
        w.slot_inc  = 1'b1;
      end
      ST_COPY: begin
        w.mem_op    = MEM_WR;
        w.wdata_sel = WD_STAGE;
        w.idx_inc   = 1'b1;
        w.cond      = C_LAST_BYTE;
        w.hold      = 1'b1;
        w.target    = ST_EMIT;
      end
      ST_EMIT: begin
        w.emit   = EMIT_SAVE;
        w.cond   = C_ALWAYS;
        w.target = ST_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/rrs_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on rrs_pkg for the control word, status struct and program.
module rrs_seq
  import rrs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o,
  output logic  busy_o
);

  step_t pc_q, pc_d;
  ctrl_t word;
  logic  cond_hit;
  logic  take;

  assign word   = ucode(pc_q);
  assign ctrl_o = word;
  assign busy_o = (pc_q != ST_IDLE);

  always_comb begin
    case (word.cond)
      C_NEVER:     cond_hit = 1'b0;
      C_ALWAYS:    cond_hit = 1'b1;
      C_MARK_CLR:  cond_hit = stat_i.mark_clr;
      C_LAST_SLOT: cond_hit = stat_i.last_slot;
      C_IS_SAVE:   cond_hit = stat_i.is_save;
      C_LAST_BYTE: cond_hit = stat_i.last_byte;
      C_DIFF:      cond_hit = stat_i.diff;
      default:     cond_hit = 1'b0;
    endcase
  end

  assign take = cond_hit ^ word.cond_inv;

  always_comb begin
    if (pc_q == ST_IDLE) begin
      pc_d = stat_i.go ? ST_SCAN_RD : ST_IDLE;
    end else if (take) begin
      pc_d = word.target;
    end else if (word.hold) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// File: hw/rtl/rrs_datapath.sv
// Datapath: record memory with per-slot valid bits, staging bytes, slot and
// byte counters, compare flag and result register. Depends on rrs_pkg.
module rrs_datapath
  import rrs_pkg::*;
#(
  parameter int unsigned RECORD_BYTES = DEF_RECORD_BYTES,
  parameter int unsigned SLOT_COUNT   = DEF_SLOT_COUNT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic                  kind_i,
  input  logic [BYTE_W-1:0]     data_i,
  input  ctrl_t                 ctrl_i,
  output stat_t                 stat_o,
  output logic                  res_valid_o,
  output logic                  answer_kind_o,
  output logic                  found_o,
  output logic [BYTE_W-1:0]     byte_out_o,
  output logic                  written_o,
  output logic [SLOT_OUT_W-1:0] slot_o,
  output logic                  final_res_o
);

  localparam int unsigned SlotW    = $clog2(SLOT_COUNT);
  localparam int unsigned IdxW     = $clog2(RECORD_BYTES);
  localparam int unsigned MemDepth = RECORD_BYTES * SLOT_COUNT;
  localparam int unsigned AddrW    = $clog2(MemDepth);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(SLOT_COUNT - 1);
  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(RECORD_BYTES - 1);

  logic [BYTE_W-1:0] mem [MemDepth];
  logic [BYTE_W-1:0] stage_q [RECORD_BYTES];
  logic [SLOT_COUNT-1:0] vld_q;

  logic [IdxW-1:0]   cnt_q;
  logic [SlotW-1:0]  slot_q, slot_nx, a_slot;
  logic [IdxW-1:0]   idx_q, idx_nx, a_idx;
  logic              is_save_q;
  logic              diff_q;
  logic [BYTE_W-1:0] rd_q;
  logic              rd_vld_q;
  logic              out_vld_q;

  logic              go;
  logic              first;
  logic [AddrW-1:0]  addr;
  logic [BYTE_W-1:0] rd_eff, rd_m, st_m, wdata;

  assign go      = accept_i && (kind_i || (cnt_q == LastIdx));
  assign slot_nx = (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
  assign idx_nx  = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
  assign first   = (idx_q == '0);

  always_comb begin
    case (ctrl_i.addr_sel)
      ADDR_CUR: begin
        a_slot = slot_q;
        a_idx  = idx_q;
      end
      ADDR_SLOT_NEXT: begin
        a_slot = slot_nx;
        a_idx  = idx_q;
      end
      ADDR_IDX_NEXT: begin
        a_slot = slot_q;
        a_idx  = idx_nx;
      end
      default: begin
        a_slot = slot_q;
        a_idx  = idx_q;
      end
    endcase
  end

  assign addr = AddrW'(a_slot) * AddrW'(RECORD_BYTES) + AddrW'(a_idx);

  // A slot that was never written reads as erased.
  assign rd_eff = rd_vld_q ? rd_q : BYTE_ERASED;
  assign rd_m   = first ? (rd_eff & MARK_MASK) : rd_eff;
  assign st_m   = first ? (stage_q[idx_q] & MARK_MASK) : stage_q[idx_q];
  assign wdata  = (ctrl_i.wdata_sel == WD_STAGE) ? st_m : BYTE_ERASED;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_op == MEM_WR) begin
      mem[addr] <= wdata;
    end
    if (ctrl_i.mem_op == MEM_RD) begin
      rd_q     <= mem[addr];
      rd_vld_q <= vld_q[a_slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !kind_i) begin
      stage_q[cnt_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      cnt_q     <= '0;
      slot_q    <= '0;
      idx_q     <= '0;
      is_save_q <= 1'b0;
      diff_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if ((ctrl_i.mem_op == MEM_WR) && (ctrl_i.wdata_sel == WD_STAGE)) begin
        vld_q[a_slot] <= 1'b1;
      end
      if (accept_i && !kind_i) begin
        cnt_q <= (cnt_q == LastIdx) ? '0 : cnt_q + 1'b1;
      end
      if (go) begin
        is_save_q <= !kind_i;
        slot_q    <= '0;
        idx_q     <= '0;
        diff_q    <= 1'b0;
      end else begin
        if (ctrl_i.slot_inc) begin
          slot_q <= slot_nx;
        end
        if (ctrl_i.idx_inc) begin
          idx_q <= idx_nx;
        end
        if (ctrl_i.diff_acc && (rd_m != st_m)) begin
          diff_q <= 1'b1;
        end
      end
      out_vld_q <= (ctrl_i.emit != EMIT_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.emit)
      EMIT_NOTFOUND: begin
        answer_kind_o <= 1'b1;
        found_o       <= 1'b0;
        byte_out_o    <= '0;
        written_o     <= 1'b0;
        slot_o        <= '0;
        final_res_o   <= 1'b1;
      end
      EMIT_LOAD: begin
        answer_kind_o <= 1'b1;
        found_o       <= 1'b1;
        byte_out_o    <= rd_m;
        written_o     <= 1'b0;
        slot_o        <= SLOT_OUT_W'(slot_q);
        final_res_o   <= (idx_q == LastIdx);
      end
      EMIT_SAVE: begin
        answer_kind_o <= 1'b0;
        found_o       <= 1'b0;
        byte_out_o    <= '0;
        written_o     <= diff_q;
        slot_o        <= SLOT_OUT_W'(slot_q);
        final_res_o   <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res_valid_o = out_vld_q;

  assign stat_o.go        = go;
  assign stat_o.mark_clr  = !rd_eff[BYTE_W-1];
  assign stat_o.last_slot = (slot_q == LastSlot);
  assign stat_o.is_save   = is_save_q;
  assign stat_o.last_byte = (idx_q == LastIdx);
  assign stat_o.diff      = diff_q;

endmodule

// File: hw/rtl/rotating_record_store_unit.sv
// Top level of the rotating record store: microcode sequencer plus datapath.
// Depends on rrs_pkg, rrs_seq and rrs_datapath.
//
//  channel  | signals                                     | direction | flow control
//  ---------+---------------------------------------------+-----------+----------------------
//  request  | start, kind_i, data_i                       | in        | taken when !busy
//  result   | res_valid_o, answer_kind_o, found_o,        | out       | one-cycle strobe,
//           | byte_out_o, written_o, slot_o, final_res_o  |           | cannot be held off
//
// A save byte that is not the last is only staged and leaves the block idle. In a load
// or a completing save the marker scan runs a check step and a next step per slot,
// and every record byte passes the single memory port once per pass.
// After reset all slots read as erased through per-slot valid bits; no clearing pass.
// Results leave through a register, so the last strobe overlaps the first idle cycle.
module rotating_record_store_unit
  import rrs_pkg::*;
#(
  parameter int unsigned RECORD_BYTES = DEF_RECORD_BYTES,
  parameter int unsigned SLOT_COUNT   = DEF_SLOT_COUNT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  kind_i,
  input  logic [BYTE_W-1:0]     data_i,
  output logic                  res_valid_o,
  output logic                  answer_kind_o,
  output logic                  found_o,
  output logic [BYTE_W-1:0]     byte_out_o,
  output logic                  written_o,
  output logic [SLOT_OUT_W-1:0] slot_o,
  output logic                  final_res_o
);

  ctrl_t ctrl;
  stat_t stat;
  logic  accept;

  assign accept = start && !busy;

  rrs_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy)
  );

  rrs_datapath #(
    .RECORD_BYTES (RECORD_BYTES),
    .SLOT_COUNT   (SLOT_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .kind_i        (kind_i),
    .data_i        (data_i),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .res_valid_o   (res_valid_o),
    .answer_kind_o (answer_kind_o),
    .found_o       (found_o),
    .byte_out_o    (byte_out_o),
    .written_o     (written_o),
    .slot_o        (slot_o),
    .final_res_o   (final_res_o)
  );

endmodule

// File: hw/rtl/rrs_checker.sv
// Port-level checker for the rotating record store, bound to the top level.
// Depends on rrs_pkg for field widths.
module rrs_checker
  import rrs_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  busy,
  input logic                  res_valid_o,
  input logic                  answer_kind_o,
  input logic                  found_o,
  input logic [BYTE_W-1:0]     byte_out_o,
  input logic                  written_o,
  input logic [SLOT_OUT_W-1:0] slot_o,
  input logic                  final_res_o
);

  // A result only follows a cycle in which the block was working.
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result strobe without preceding busy cycle");

  // The last result of a request is never followed directly by another.
  a_final_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && final_res_o |=> !res_valid_o)
    else $error("result strobe right after a final result");

  // More load bytes are still coming, so the block must stay busy.
  a_busy_until_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !final_res_o |-> busy)
    else $error("non-final result while idle");

  a_save_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !answer_kind_o |-> final_res_o && !found_o && (byte_out_o == '0))
    else $error("malformed save outcome");

  a_notfound_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && answer_kind_o && !found_o |->
      final_res_o && !written_o && (slot_o == '0) && (byte_out_o == '0))
    else $error("malformed not-found answer");

endmodule

bind rotating_record_store_unit rrs_checker u_rrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .busy          (busy),
  .res_valid_o   (res_valid_o),
  .answer_kind_o (answer_kind_o),
  .found_o       (found_o),
  .byte_out_o    (byte_out_o),
  .written_o     (written_o),
  .slot_o        (slot_o),
  .final_res_o   (final_res_o)
);

// File: sim/rrs_tb_pkg.sv
// Scoreboard of the rotating record store testbench: result type and a predictor class.
// Depends on rrs_pkg for widths and byte constants; used by tb_top.
`timescale 1ns / 100ps

package rrs_tb_pkg;
  import rrs_pkg::*;

  localparam int unsigned REC_N  = DEF_RECORD_BYTES;
  localparam int unsigned SLOT_N = DEF_SLOT_COUNT;

  localparam logic KIND_SAVE = 1'b0;
  localparam logic KIND_LOAD = 1'b1;
  localparam logic ANS_SAVE  = 1'b0;
  localparam logic ANS_LOAD  = 1'b1;

  localparam logic [BYTE_W-1:0] MARK_BIT    = ~MARK_MASK;
  localparam int unsigned       MAX_REPORTS = 40;

  typedef struct packed {
    logic                  answer_kind;
    logic                  found;
    logic [BYTE_W-1:0]     byte_out;
    logic                  written;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  final_res;
  } answer_t;

  class record_store_scoreboard;
    logic [BYTE_W-1:0] slots_mem [SLOT_N*REC_N];
    logic [BYTE_W-1:0] staged [REC_N];
    int unsigned       staged_cnt;
    answer_t           awaited[$];
    int unsigned       mismatches;

    function new();
      foreach (slots_mem[i]) slots_mem[i] = BYTE_ERASED;
      foreach (staged[i]) staged[i] = '0;
      staged_cnt = 0;
      mismatches = 0;
    endfunction

    // Lowest slot whose marker bit is clear, or -1 when every slot is erased.
    function int live_slot();
      for (int s = 0; s < SLOT_N; s++) begin
        if ((slots_mem[s*REC_N] & MARK_BIT) == '0) return s;
      end
      return -1;
    endfunction

    // Byte of the record a save would be compared against.
    function logic [BYTE_W-1:0] record_byte(int unsigned idx);
      int s;
      s = live_slot();
      if (s < 0) s = 0;
      return slots_mem[s*REC_N + idx];
    endfunction

    function void add_answer(logic ak, logic fnd, logic [BYTE_W-1:0] b, logic wr,
                             logic [SLOT_OUT_W-1:0] sl, logic fin);
      answer_t a;
      a.answer_kind = ak;
      a.found       = fnd;
      a.byte_out    = b;
      a.written     = wr;
      a.slot        = sl;
      a.final_res   = fin;
      awaited.push_back(a);
    endfunction

    function void note_request(logic kind, logic [BYTE_W-1:0] data);
      int                s;
      int unsigned       nxt;
      bit                differ;
      logic [BYTE_W-1:0] old_b;
      logic [BYTE_W-1:0] new_b;
      s = live_slot();
      if (kind == KIND_LOAD) begin
        if (s < 0) begin
          add_answer(ANS_LOAD, 1'b0, '0, 1'b0, '0, 1'b1);
        end else begin
          for (int i = 0; i < REC_N; i++) begin
            old_b = slots_mem[s*REC_N + i];
            if (i == 0) old_b &= MARK_MASK;
            add_answer(ANS_LOAD, 1'b1, old_b, 1'b0, SLOT_OUT_W'(s), i == REC_N - 1);
          end
        end
        return;
      end
      staged[staged_cnt] = data;
      staged_cnt++;
      if (staged_cnt < REC_N) return;
      staged_cnt = 0;
      if (s < 0) s = 0;
      differ = 1'b0;
      for (int i = 0; i < REC_N; i++) begin
        old_b = slots_mem[s*REC_N + i];
        new_b = staged[i];
        if (i == 0) begin
          old_b &= MARK_MASK;
          new_b &= MARK_MASK;
        end
        if (old_b != new_b) differ = 1'b1;
      end
      if (!differ) begin
        add_answer(ANS_SAVE, 1'b0, '0, 1'b0, SLOT_OUT_W'(s), 1'b1);
        return;
      end
      // The old slot loses its marker before the record moves on, wrapping at the end.
      slots_mem[s*REC_N] = BYTE_ERASED;
      nxt = (s + 1) % SLOT_N;
      for (int i = 0; i < REC_N; i++) begin
        new_b = staged[i];
        if (i == 0) new_b &= MARK_MASK;
        slots_mem[nxt*REC_N + i] = new_b;
      end
      add_answer(ANS_SAVE, 1'b0, '0, 1'b1, SLOT_OUT_W'(nxt), 1'b1);
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    task report(string msg);
      if (mismatches < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
      if (got !== want) report($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    task check_result(answer_t got);
      answer_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing pending: kind %0d byte %0h slot %0d",
                         got.answer_kind, got.byte_out, got.slot));
        return;
      end
      want = awaited.pop_front();
      compare_field("answer_kind", BYTE_W'(got.answer_kind), BYTE_W'(want.answer_kind));
      compare_field("found", BYTE_W'(got.found), BYTE_W'(want.found));
      compare_field("byte_out", got.byte_out, want.byte_out);
      compare_field("written", BYTE_W'(got.written), BYTE_W'(want.written));
      compare_field("slot", BYTE_W'(got.slot), BYTE_W'(want.slot));
      compare_field("final_res", BYTE_W'(got.final_res), BYTE_W'(want.final_res));
    endtask
  endclass

endpackage

// File: sim/tb_top.sv
// Top of the rotating record store testbench: clock, reset, request driver and result monitor.
// Depends on rrs_pkg, rrs_tb_pkg and the rotating_record_store_unit RTL.
`timescale 1ns / 100ps

module tb_top;
  import rrs_pkg::*;
  import rrs_tb_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 116;
  localparam int unsigned DRAIN_CYCLES = 2*SLOT_N + 2*REC_N + 16;
  localparam int unsigned STALL_LIMIT  = 2000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic                  kind_i;
  logic [BYTE_W-1:0]     data_i;
  logic                  res_valid_o;
  logic                  answer_kind_o;
  logic                  found_o;
  logic [BYTE_W-1:0]     byte_out_o;
  logic                  written_o;
  logic [SLOT_OUT_W-1:0] slot_o;
  logic                  final_res_o;

  record_store_scoreboard store_model;
  int unsigned            random_sent;
  int unsigned            quiet_cycles;
  bit                     steady;

  rotating_record_store_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .data_i       (data_i),
    .res_valid_o  (res_valid_o),
    .answer_kind_o(answer_kind_o),
    .found_o      (found_o),
    .byte_out_o   (byte_out_o),
    .written_o    (written_o),
    .slot_o       (slot_o),
    .final_res_o  (final_res_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Random sender gaps, except during the steady stretch.
  task automatic idle_maybe();
    if (!steady && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Holds the request until a clock edge sees busy low; start stays high afterwards.
  task automatic issue(input logic kind, input logic [BYTE_W-1:0] data);
    idle_maybe();
    start  <= 1'b1;
    kind_i <= kind;
    data_i <= data;
    do @(posedge clk_i); while (busy !== 1'b0);
    store_model.note_request(kind, data);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (store_model.pending() != 0);
  endtask

  task automatic save_record(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] rest);
    for (int i = 0; i < REC_N; i++) issue(KIND_SAVE, (i == 0) ? b0 : rest ^ BYTE_W'(i));
  endtask

  task automatic random_record();
    bit                repeat_rec;
    bit                broken;
    logic [BYTE_W-1:0] b;
    repeat_rec = $urandom_range(0, 99) < 25;
    broken     = $urandom_range(0, 99) < 5;
    for (int i = 0; i < REC_N; i++) begin
      if (repeat_rec) begin
        // Same content as the live record; the marker bit may differ, which must not matter.
        b = store_model.record_byte(i);
        if (i == 0 && $urandom_range(0, 1)) b ^= MARK_BIT;
      end else begin
        case ($urandom_range(0, 9))
          0:       b = '0;
          1:       b = BYTE_ERASED;
          default: b = BYTE_W'($urandom_range(0, 255));
        endcase
      end
      if ($urandom_range(0, 99) < 8) begin
        issue(KIND_LOAD, BYTE_W'($urandom_range(0, 255)));
        random_sent++;
      end
      issue(KIND_SAVE, b);
      random_sent++;
      if (broken && i == REC_N / 2) break;
    end
  endtask

  always @(posedge clk_i) begin
    answer_t got;
    if (rst_ni && res_valid_o === 1'b1) begin
      got.answer_kind = answer_kind_o;
      got.found       = found_o;
      got.byte_out    = byte_out_o;
      got.written     = written_o;
      got.slot        = slot_o;
      got.final_res   = final_res_o;
      store_model.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start === 1'b1 && busy === 1'b0) || res_valid_o === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    bit paused_mid;
    store_model  = new();
    random_sent  = 0;
    quiet_cycles = 0;
    steady       = 1'b0;
    paused_mid   = 1'b0;
    rst_ni <= 1'b0;
    start  <= 1'b0;
    kind_i <= KIND_SAVE;
    data_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Nothing stored yet: a load finds nothing, and the first save, compared against erased slot 0, lands in slot 1.
    issue(KIND_LOAD, BYTE_ERASED);
    save_record(BYTE_ERASED, BYTE_ERASED ^ BYTE_W'(1));
    save_record(BYTE_ERASED, BYTE_ERASED);
    save_record('0, '0);
    // Load in the middle of a save; the first byte carries a set marker bit.
    issue(KIND_SAVE, MARK_BIT);
    issue(KIND_SAVE, 8'h55);
    issue(KIND_LOAD, 8'hAA);
    for (int i = 2; i < REC_N; i++) issue(KIND_SAVE, BYTE_W'(1 << (i - 2)) | MARK_MASK);
    drain_results();

    while (random_sent < RANDOM_ITEMS) begin
      steady = (random_sent >= 40 && random_sent < 80);
      if (!paused_mid && random_sent >= RANDOM_ITEMS / 2) begin
        paused_mid = 1'b1;
        drain_results();
      end
      if ($urandom_range(0, 99) < 12) begin
        issue(KIND_LOAD, BYTE_W'($urandom_range(0, 255)));
        random_sent++;
      end else begin
        random_record();
      end
    end

    start <= 1'b0;
    while (store_model.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (store_model.mismatches == 0 && store_model.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
